// ===== hdl/trlc_pkg.sv =====
// ----------------------------------------------------------------------------
// trlc_pkg
// Shared types, wiring tables and rotor helper functions for the three-rotor
// letter cipher.
// ----------------------------------------------------------------------------
package trlc_pkg;

    typedef logic [4:0] letter_t;

    localparam logic [5:0] NUM_LETTERS  = 6'd26;
    localparam letter_t    NOTCH_FAST   = 5'd16;   // Q
    localparam letter_t    NOTCH_MIDDLE = 5'd4;    // E

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_START_FAST   = 2'd0,
        REG_START_MIDDLE = 2'd1,
        REG_START_SLOW   = 2'd2,
        REG_DECRYPT_MODE = 2'd3
    } reg_index_t;

    // Request kinds carried on s_tuser.
    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_LETTER = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        W_I_FWD   = 3'd0,
        W_II_FWD  = 3'd1,
        W_III_FWD = 3'd2,
        W_I_INV   = 3'd3,
        W_II_INV  = 3'd4,
        W_III_INV = 3'd5
    } wiring_t;

    localparam letter_t WIRING [6][26] = '{
        '{5'd4,  5'd10, 5'd12, 5'd5,  5'd11, 5'd6,  5'd3,  5'd16, 5'd21, 5'd25,
          5'd13, 5'd19, 5'd14, 5'd22, 5'd24, 5'd7,  5'd23, 5'd20, 5'd18, 5'd15,
          5'd0,  5'd8,  5'd1,  5'd17, 5'd2,  5'd9},
        '{5'd0,  5'd9,  5'd3,  5'd10, 5'd18, 5'd8,  5'd17, 5'd20, 5'd23, 5'd1,
          5'd11, 5'd7,  5'd22, 5'd19, 5'd12, 5'd2,  5'd16, 5'd6,  5'd25, 5'd13,
          5'd15, 5'd24, 5'd5,  5'd21, 5'd14, 5'd4},
        '{5'd1,  5'd3,  5'd5,  5'd7,  5'd9,  5'd11, 5'd2,  5'd15, 5'd17, 5'd19,
          5'd23, 5'd21, 5'd25, 5'd13, 5'd24, 5'd4,  5'd8,  5'd22, 5'd6,  5'd0,
          5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14},
        '{5'd20, 5'd22, 5'd24, 5'd6,  5'd0,  5'd3,  5'd5,  5'd15, 5'd21, 5'd25,
          5'd1,  5'd4,  5'd2,  5'd10, 5'd12, 5'd19, 5'd7,  5'd23, 5'd18, 5'd11,
          5'd17, 5'd8,  5'd13, 5'd16, 5'd14, 5'd9},
        '{5'd0,  5'd9,  5'd15, 5'd2,  5'd25, 5'd22, 5'd17, 5'd11, 5'd5,  5'd1,
          5'd3,  5'd10, 5'd14, 5'd19, 5'd24, 5'd20, 5'd16, 5'd6,  5'd4,  5'd13,
          5'd7,  5'd23, 5'd12, 5'd8,  5'd21, 5'd18},
        '{5'd19, 5'd0,  5'd6,  5'd1,  5'd15, 5'd2,  5'd18, 5'd3,  5'd16, 5'd4,
          5'd20, 5'd5,  5'd21, 5'd13, 5'd25, 5'd7,  5'd24, 5'd8,  5'd23, 5'd9,
          5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12}
    };

    // One queue entry: letter plus the rotor positions after stepping.
    typedef struct packed {
        letter_t letter;
        letter_t fast_pos;
        letter_t middle_pos;
        letter_t slow_pos;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic [QUEUE_CW-1:0] count;
        logic                empty;
        logic                full;
    } q_status_t;

    // Reduce a 5-bit value modulo 26.
    function automatic letter_t wrap26(input letter_t v);
        letter_t r;
        if ({1'b0, v} >= NUM_LETTERS)
            r = v - NUM_LETTERS[4:0];
        else
            r = v;
        return r;
    endfunction

    // Advance a rotor position by one with wrap at 26.
    function automatic letter_t inc26(input letter_t v);
        return wrap26(v + 5'd1);
    endfunction

    // One rotor pass: shift in by pos, substitute, shift back out by pos.
    function automatic letter_t rotor_pass(input wiring_t w, input letter_t n,
                                           input letter_t pos);
        logic [5:0] idx;
        logic [5:0] diff;
        letter_t    sub;
        idx = {1'b0, n} + {1'b0, pos};
        if (idx >= NUM_LETTERS)
            idx = idx - NUM_LETTERS;
        sub  = WIRING[w][idx[4:0]];
        diff = {1'b0, sub} + NUM_LETTERS - {1'b0, pos};
        if (diff >= NUM_LETTERS)
            diff = diff - NUM_LETTERS;
        return diff[4:0];
    endfunction

endpackage

// ===== hdl/trlc_front.sv =====
// ----------------------------------------------------------------------------
// trlc_front
// Accepts requests, loads or steps the rotor positions, and queues letter
// transactions together with their stepped positions.
// ----------------------------------------------------------------------------
module trlc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,     // [4:0] letter_in, [7:5] zero
    input  logic [0:0]          s_tuser,     // [0] req_type
    input  trlc_pkg::letter_t   start_fast,
    input  trlc_pkg::letter_t   start_middle,
    input  trlc_pkg::letter_t   start_slow,
    input  trlc_pkg::q_status_t q_status,
    output trlc_pkg::q_push_t   q_push
);
    import trlc_pkg::*;

    letter_t fast_pos_reg,   fast_pos_next;
    letter_t middle_pos_reg, middle_pos_next;
    letter_t slow_pos_reg,   slow_pos_next;

    logic    accept;
    logic    carry_mid;
    logic    carry_slow;
    letter_t step_fast;
    letter_t step_middle;
    letter_t step_slow;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    // The notch test looks at the wired letter under the old position.
    always_comb
    begin
        carry_mid   = (WIRING[W_I_FWD][fast_pos_reg] == NOTCH_FAST);
        carry_slow  = carry_mid && (WIRING[W_II_FWD][middle_pos_reg] == NOTCH_MIDDLE);
        step_fast   = inc26(fast_pos_reg);
        step_middle = carry_mid  ? inc26(middle_pos_reg) : middle_pos_reg;
        step_slow   = carry_slow ? inc26(slow_pos_reg)   : slow_pos_reg;
    end

    always_comb
    begin
        fast_pos_next   = fast_pos_reg;
        middle_pos_next = middle_pos_reg;
        slow_pos_next   = slow_pos_reg;
        q_push.valid             = 1'b0;
        q_push.entry.letter      = wrap26(s_tdata[4:0]);
        q_push.entry.fast_pos    = step_fast;
        q_push.entry.middle_pos  = step_middle;
        q_push.entry.slow_pos    = step_slow;
        if (accept)
        begin
            unique case (req_type_t'(s_tuser[0]))
                REQ_LOAD:
                begin
                    fast_pos_next   = wrap26(start_fast);
                    middle_pos_next = wrap26(start_middle);
                    slow_pos_next   = wrap26(start_slow);
                end
                REQ_LETTER:
                begin
                    fast_pos_next   = step_fast;
                    middle_pos_next = step_middle;
                    slow_pos_next   = step_slow;
                    q_push.valid    = 1'b1;
                end
                default:
                begin
                    q_push.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_pos_reg   <= '0;
            middle_pos_reg <= '0;
            slow_pos_reg   <= '0;
        end
        else
        begin
            fast_pos_reg   <= fast_pos_next;
            middle_pos_reg <= middle_pos_next;
            slow_pos_reg   <= slow_pos_next;
        end
    end

endmodule

// ===== hdl/trlc_queue.sv =====
// ----------------------------------------------------------------------------
// trlc_queue
// Small FIFO that decouples the stepping front from the substitution back.
// ----------------------------------------------------------------------------
module trlc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  trlc_pkg::q_push_t   q_push,
    input  logic                pop,
    output trlc_pkg::q_entry_t  head,
    output trlc_pkg::q_status_t q_status
);
    import trlc_pkg::*;

    q_entry_t mem [QUEUE_DEPTH];

    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg,  count_next;
    logic                do_push;
    logic                do_pop;

    assign q_status.count = count_reg;
    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));

    assign do_push = q_push.valid && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= q_push.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/trlc_back.sv =====
// ----------------------------------------------------------------------------
// trlc_back
// Runs queued letters through the three rotor passes in two pipeline stages
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module trlc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                decrypt_mode,
    input  trlc_pkg::q_entry_t  head,
    input  trlc_pkg::q_status_t q_status,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata      // [4:0] letter_out, [7:5] zero
);
    import trlc_pkg::*;

    logic    a_valid_reg, a_valid_next;
    letter_t a_letter_reg;
    letter_t a_pos2_reg;
    letter_t a_pos3_reg;
    logic    a_decrypt_reg;

    logic    out_valid_reg, out_valid_next;
    letter_t out_letter_reg;

    logic    out_adv;
    logic    a_adv;
    letter_t pass1;
    letter_t pass2;
    letter_t pass3;

    assign out_adv = !out_valid_reg || m_tready;
    assign a_adv   = !a_valid_reg || out_adv;
    assign pop     = a_adv && !q_status.empty;

    // Encrypt runs fast, middle, slow; decrypt runs the inverses slow, middle, fast.
    always_comb
    begin
        pass1 = decrypt_mode ? rotor_pass(W_III_INV, head.letter, head.slow_pos)
                             : rotor_pass(W_I_FWD,   head.letter, head.fast_pos);
        pass2 = rotor_pass(a_decrypt_reg ? W_II_INV : W_II_FWD, a_letter_reg, a_pos2_reg);
        pass3 = rotor_pass(a_decrypt_reg ? W_I_INV : W_III_FWD, pass2, a_pos3_reg);
        a_valid_next   = a_adv   ? pop         : a_valid_reg;
        out_valid_next = out_adv ? a_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_letter_reg  <= pass1;
            a_pos2_reg    <= head.middle_pos;
            a_pos3_reg    <= decrypt_mode ? head.fast_pos : head.slow_pos;
            a_decrypt_reg <= decrypt_mode;
        end
        if (out_adv && a_valid_reg)
            out_letter_reg <= pass3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_letter_reg};

endmodule

// ===== hdl/three_rotor_letter_cipher_unit.sv =====
// A letter passes through the queue, the stage A registers and the output register to m_tdata.
// Throughput: one request per cycle while the queue is not full; s_tready drops when it is full.
// Load requests produce no output transaction.
// Reset (rst_n low, asynchronous) clears rotor positions, registers and the queue.
// ----------------------------------------------------------------------------
// three_rotor_letter_cipher_unit
// Three-rotor letter cipher: stepping front, queue, pipelined substitution
// back, and an APB-style register port.
// ----------------------------------------------------------------------------
module three_rotor_letter_cipher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [4:0] letter_in, [7:5] zero
    input  logic [0:0]  s_tuser,     // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata      // [4:0] letter_out, [7:5] zero
);
    import trlc_pkg::*;

    letter_t start_fast_reg;
    letter_t start_middle_reg;
    letter_t start_slow_reg;
    logic    decrypt_mode_reg;

    logic       cfg_write;
    reg_index_t cfg_index;

    q_push_t   q_push;
    q_status_t q_status;
    q_entry_t  head;
    logic      pop;

    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_index)
            REG_START_FAST:   prdata = {27'd0, start_fast_reg};
            REG_START_MIDDLE: prdata = {27'd0, start_middle_reg};
            REG_START_SLOW:   prdata = {27'd0, start_slow_reg};
            REG_DECRYPT_MODE: prdata = {31'd0, decrypt_mode_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_fast_reg   <= '0;
            start_middle_reg <= '0;
            start_slow_reg   <= '0;
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START_FAST:   start_fast_reg   <= pwdata[4:0];
                REG_START_MIDDLE: start_middle_reg <= pwdata[4:0];
                REG_START_SLOW:   start_slow_reg   <= pwdata[4:0];
                REG_DECRYPT_MODE: decrypt_mode_reg <= pwdata[0];
                default:          decrypt_mode_reg <= decrypt_mode_reg;
            endcase
        end
    end

    trlc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .start_fast   (start_fast_reg),
        .start_middle (start_middle_reg),
        .start_slow   (start_slow_reg),
        .q_status     (q_status),
        .q_push       (q_push)
    );

    trlc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    trlc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .decrypt_mode (decrypt_mode_reg),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // The queue never holds more entries than it has room for.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    // A load request adds nothing to the queue.
    a_load_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0] == REQ_LOAD)
        |=> q_status.count <= $past(q_status.count))
        else $error("load transaction entered the queue");

    // An accepted letter is in the queue on the next cycle.
    a_letter_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0] == REQ_LETTER) |=> !q_status.empty)
        else $error("letter transaction was not queued");
`endif

endmodule
